/* src/hscfr_pkg.sv */
// Shared constants and types for the header-sync checksum frame receiver.
`timescale 1ns / 1ps

package hscfr_pkg;

  localparam int FRAME_LEN = 16;
  localparam int BYTE_W    = 8;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = $clog2(FRAME_LEN);
  localparam int ADDR_W    = CNT_W + 1;
  localparam int MEM_DEPTH = 2 ** ADDR_W;

  localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hDD;
  localparam logic [CNT_W-1:0]  LAST_IDX   = CNT_W'(FRAME_LEN - 1);
  localparam logic [1:0]        BANKS_ALL  = 2'd2;

  // Buffer write from the front end, with the frame-passed mark
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
    logic              pass;
  } wr_t;

  // Buffer status back to the front end
  typedef struct packed {
    logic banks_full;
  } st_t;

endpackage

/* src/hscfr_front.sv */
// Front end: header hunt, byte collection, checksum and buffer writes.
`timescale 1ns / 1ps

module hscfr_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [hscfr_pkg::BYTE_W-1:0] rx_byte,
  input  logic                       cfg_we,
  input  logic [hscfr_pkg::BYTE_W-1:0] cfg_wdata,
  input  hscfr_pkg::st_t             st,
  output logic                       full,
  output hscfr_pkg::wr_t             wr
);
  import hscfr_pkg::*;

  typedef enum logic [1:0] {
    HUNT    = 2'b01,
    COLLECT = 2'b10
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  byte_count, byte_count_next;
  logic [BYTE_W-1:0] running_sum, running_sum_next;
  logic              wr_bank, wr_bank_next;
  logic [BYTE_W-1:0] sync_byte;
  logic              accept;

  // stall while both frame banks wait to drain
  assign full   = st.banks_full;
  assign accept = push & ~full;

  // next-state and buffer write
  always_comb begin
    state_next       = state;
    byte_count_next  = byte_count;
    running_sum_next = running_sum;
    wr_bank_next     = wr_bank;
    wr.we            = 1'b0;
    wr.pass          = 1'b0;
    wr.addr          = {wr_bank, byte_count};
    wr.data          = rx_byte;
    if (accept) begin
      unique case (state)
        HUNT: begin
          if (rx_byte == sync_byte) begin
            wr.we            = 1'b1;
            running_sum_next = rx_byte;
            byte_count_next  = CNT_W'(1);
            state_next       = COLLECT;
          end
        end
        COLLECT: begin
          wr.we = 1'b1;
          if (byte_count != LAST_IDX) begin
            running_sum_next = running_sum + rx_byte;
            byte_count_next  = byte_count + CNT_W'(1);
          end else begin
            // checksum word: frame passes only on a match
            wr.pass          = (running_sum == rx_byte);
            wr_bank_next     = wr_bank ^ (running_sum == rx_byte);
            byte_count_next  = '0;
            running_sum_next = '0;
            state_next       = HUNT;
          end
        end
        default: begin
          state_next = HUNT;
        end
      endcase
    end
  end

  // state registers and sync register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= HUNT;
      byte_count  <= '0;
      running_sum <= '0;
      wr_bank     <= 1'b0;
      sync_byte   <= SYNC_RESET;
    end else begin
      state       <= state_next;
      byte_count  <= byte_count_next;
      running_sum <= running_sum_next;
      wr_bank     <= wr_bank_next;
      if (cfg_we) begin
        sync_byte <= cfg_wdata;
      end
    end
  end

  // a passed frame always ends on the last position of its bank
  a_pass_at_end: assert property (@(posedge clk) disable iff (rst)
    wr.pass |-> (wr.we && byte_count == LAST_IDX && state == COLLECT))
    else $error("frame pass outside final word");

endmodule

/* src/hscfr_back.sv */
// Back end: two-bank frame buffer, drain sequencer and output queue.
`timescale 1ns / 1ps

module hscfr_back (
  input  logic                         clk,
  input  logic                         rst,
  input  hscfr_pkg::wr_t               wr,
  output hscfr_pkg::st_t               st,
  input  logic                         pop,
  output logic                         empty,
  output logic [hscfr_pkg::BYTE_W-1:0] frame_byte,
  output logic [hscfr_pkg::IDX_W-1:0]  byte_index,
  output logic                         frame_last
);
  import hscfr_pkg::*;

  logic [BYTE_W-1:0] mem [MEM_DEPTH];
  logic [BYTE_W-1:0] mem_q;

  logic [1:0]        pending, pending_next;
  logic              rd_bank;
  logic [CNT_W-1:0]  rd_idx;
  logic              issue, rd_done;

  logic              infl_valid;
  logic [CNT_W-1:0]  infl_idx;
  logic              infl_last;

  logic [BYTE_W-1:0] q_data [2];
  logic [CNT_W-1:0]  q_idx  [2];
  logic              q_last [2];
  logic              q_wr_ptr, q_rd_ptr;
  logic [1:0]        q_cnt;
  logic              pop_ok;
  logic [2:0]        q_load;

  // frame-level bookkeeping
  assign st.banks_full = (pending == BANKS_ALL);
  assign pop_ok        = pop & (q_cnt != 2'd0);
  assign q_load        = {1'b0, q_cnt} + {2'b0, infl_valid} - {2'b0, pop_ok};
  assign issue         = (pending != 2'd0) && (q_load < 3'd2);
  assign rd_done       = issue && (rd_idx == LAST_IDX);
  assign pending_next  = pending + {1'b0, wr.pass} - {1'b0, rd_done};

  // frame buffer, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    if (issue) begin
      mem_q <= mem[{rd_bank, rd_idx}];
    end
  end

  // drain sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= '0;
      rd_bank    <= 1'b0;
      rd_idx     <= '0;
      infl_valid <= 1'b0;
    end else begin
      pending    <= pending_next;
      infl_valid <= issue;
      if (issue) begin
        rd_idx <= rd_done ? '0 : rd_idx + CNT_W'(1);
        if (rd_done) begin
          rd_bank <= ~rd_bank;
        end
      end
    end
  end

  // tags travel with the read data
  always_ff @(posedge clk) begin
    if (issue) begin
      infl_idx  <= rd_idx;
      infl_last <= rd_done;
    end
  end

  // two-entry output queue
  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr_ptr <= 1'b0;
      q_rd_ptr <= 1'b0;
      q_cnt    <= '0;
    end else begin
      if (infl_valid) begin
        q_wr_ptr <= ~q_wr_ptr;
      end
      if (pop_ok) begin
        q_rd_ptr <= ~q_rd_ptr;
      end
      q_cnt <= q_load[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (infl_valid) begin
      q_data[q_wr_ptr] <= mem_q;
      q_idx[q_wr_ptr]  <= infl_idx;
      q_last[q_wr_ptr] <= infl_last;
    end
  end

  assign empty      = (q_cnt == 2'd0);
  assign frame_byte = q_data[q_rd_ptr];
  assign byte_index = IDX_W'(q_idx[q_rd_ptr]);
  assign frame_last = q_last[q_rd_ptr];

  a_pending_range: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more frames pending than banks");

  a_queue_range: assert property (@(posedge clk) disable iff (rst)
    q_cnt != 2'd3)
    else $error("output queue overflow");

  a_no_write_when_full: assert property (@(posedge clk) disable iff (rst)
    st.banks_full |-> !wr.we)
    else $error("write into a bank still waiting to drain");

  a_last_wraps_bank: assert property (@(posedge clk) disable iff (rst)
    rd_done |=> (rd_idx == '0 && rd_bank != $past(rd_bank)))
    else $error("drain did not move to the next bank");

endmodule

/* src/header_sync_checksum_frame_receiver_unit.sv */
// Top level of the header-sync checksum frame receiver.
// Input: one word per cycle; full rises only while two passed frames still wait to drain.
// Output: a passed frame is counted pending, then read through the buffer read register into the output queue.
// Drain: FRAME_LEN words at one per cycle while the output queue has room, set by the single buffer read port.
// Reset (rst, synchronous): hunting, queues empty, sync byte back to 0xDD.
// The frame buffer holds no reset; every entry is written before it is read.
`timescale 1ns / 1ps

module header_sync_checksum_frame_receiver_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [hscfr_pkg::BYTE_W-1:0] rx_byte,
  input  logic                         cfg_we,
  input  logic [hscfr_pkg::BYTE_W-1:0] cfg_wdata,
  output logic                         empty,
  input  logic                         pop,
  output logic [hscfr_pkg::BYTE_W-1:0] frame_byte,
  output logic [hscfr_pkg::IDX_W-1:0]  byte_index,
  output logic                         frame_last
);
  import hscfr_pkg::*;

  wr_t wr;
  st_t st;

  hscfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .rx_byte   (rx_byte),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .st        (st),
    .full      (full),
    .wr        (wr)
  );

  hscfr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .wr         (wr),
    .st         (st),
    .pop        (pop),
    .empty      (empty),
    .frame_byte (frame_byte),
    .byte_index (byte_index),
    .frame_last (frame_last)
  );

endmodule
